// ===== design/rpat_pkg.sv =====
// ----------------------------------------------------------------------------
// rpat_pkg
// Shared types and constants for the recent peer address table.
// ----------------------------------------------------------------------------
package rpat_pkg;

    // default number of table slots
    localparam int unsigned TABLE_DEPTH_DEF = 16;

    // field widths
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // action codes; code 3 is ignored
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LEARN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // one stored device address
    typedef struct packed {
        logic [TYPE_W-1:0] dev_type;
        logic [ADDR_W-1:0] address;
    } t_entry;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;          // capture compare result
        logic learn;        // enabled learn, update cycle
        logic clear;        // clear whole list, update cycle
        logic load_tail;    // load key at last used slot (hit or full)
        logic shift_all;    // full and missed: evict oldest
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

endpackage

// ===== design/rpat_cell.sv =====
// ----------------------------------------------------------------------------
// rpat_cell
// One slot of the table: holds an entry, compares it to the key and takes
// its right neighbour's entry when the list closes up.
// ----------------------------------------------------------------------------
module rpat_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpat_pkg::t_cell_ctl i_ctl,
    input  rpat_pkg::t_entry    i_key,
    input  logic                i_left_valid,   // 1 for the oldest slot
    input  logic                i_right_valid,  // 0 for the newest slot
    input  rpat_pkg::t_entry    i_right_data,
    input  logic                i_shift,        // a match lies left of here
    output logic                o_shift,
    output logic                o_valid,
    output rpat_pkg::t_entry    o_data,
    output logic                o_match,
    output logic                o_last_match
);

    logic             r_valid;
    logic             n_valid;
    rpat_pkg::t_entry r_data;
    rpat_pkg::t_entry n_data;
    logic             r_match;

    logic w_last_used;
    logic w_first_free;
    logic w_load;
    logic w_move;

    // slot position in the packed list
    assign w_last_used  = r_valid & ~i_right_valid;
    assign w_first_free = ~r_valid & i_left_valid;

    assign w_load = i_ctl.learn & (i_ctl.load_tail ? w_last_used : w_first_free);
    assign w_move = i_ctl.learn & (i_ctl.shift_all | i_shift | r_match);

    // next entry
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (w_load) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end else if (w_move) begin
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp) begin
                r_match <= r_valid & (r_data == i_key);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_shift      = i_shift | r_match;
    assign o_valid      = r_valid;
    assign o_data       = r_data;
    assign o_match      = r_match;
    assign o_last_match = r_match & w_last_used;

endmodule

// ===== design/recent_peer_address_table_core.sv =====
// ----------------------------------------------------------------------------
// recent_peer_address_table_core
// Packed list of recent device addresses, oldest first, held in a row of
// cells. Lookup, learn (move to newest or append, evicting oldest) and clear.
// ----------------------------------------------------------------------------
// Flow: each accepted word gets a compare cycle, then an update cycle.
//   The update cycle loads the result, waits while the held result is not taken,
//   can accept the next word and ripples the match flag through the cell row.
// Reset: all slots empty, count zero, enable set.
// ----------------------------------------------------------------------------
module recent_peer_address_table_core #(
    parameter int unsigned TABLE_DEPTH = rpat_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // [7:0] device type, [55:8] address
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] matched, [1] changed, [6:2] entry_count
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data   // enable
);

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    rpat_pkg::t_state    r_state;
    rpat_pkg::t_state    n_state;
    rpat_pkg::t_cell_ctl w_ctl;

    logic                              r_enable;
    logic [rpat_pkg::ACTION_W-1:0]     r_action;
    rpat_pkg::t_entry                  r_key;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic                              r_m_valid;
    logic [7:0]                        r_m_data;
    logic [CW+rpat_pkg::COUNT_W-1:0]   w_count_ext;

    logic w_s_accept;
    logic w_out_free;
    logic w_upd;
    logic w_hit;
    logic w_last_hit;
    logic w_full;
    logic w_learn_en;
    logic w_matched;
    logic w_changed;

    logic             w_valid      [TABLE_DEPTH];
    rpat_pkg::t_entry w_data       [TABLE_DEPTH];
    logic             w_shift      [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_match_vec;
    logic [TABLE_DEPTH-1:0] w_last_vec;
    logic [TABLE_DEPTH-1:0] w_valid_vec;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_data;
        end
    end

    // handshake
    assign w_out_free = ~r_m_valid | i_m_tready;
    assign w_upd      = (r_state == rpat_pkg::ST_UPD) & w_out_free;
    assign o_s_tready = (r_state == rpat_pkg::ST_IDLE) | w_upd;
    assign w_s_accept = i_s_tvalid & o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpat_pkg::ST_IDLE: begin
                if (w_s_accept) begin
                    n_state = rpat_pkg::ST_CMP;
                end
            end
            rpat_pkg::ST_CMP: begin
                n_state = rpat_pkg::ST_UPD;
            end
            rpat_pkg::ST_UPD: begin
                if (w_out_free) begin
                    n_state = w_s_accept ? rpat_pkg::ST_CMP : rpat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_action       <= i_s_tuser;
            r_key.dev_type <= i_s_tdata[7:0];
            r_key.address  <= i_s_tdata[55:8];
        end
    end

    // table-wide flags from the cells
    assign w_hit      = w_shift[TABLE_DEPTH];
    assign w_last_hit = |w_last_vec;
    assign w_full     = r_count == CW'(TABLE_DEPTH);
    assign w_learn_en = (r_action == rpat_pkg::ACT_LEARN) & r_enable;

    // cell control
    always_comb begin
        w_ctl           = '0;
        w_ctl.cmp       = r_state == rpat_pkg::ST_CMP;
        w_ctl.learn     = w_upd & w_learn_en;
        w_ctl.clear     = w_upd & (r_action == rpat_pkg::ACT_CLEAR);
        w_ctl.load_tail = w_hit | w_full;
        w_ctl.shift_all = ~w_hit & w_full;
    end

    // row of cells
    assign w_shift[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic             w_left_valid;
            logic             w_right_valid;
            rpat_pkg::t_entry w_right_data;
            logic             w_match;

            if (g == 0) begin : g_first
                assign w_left_valid = 1'b1;
            end else begin : g_inner_l
                assign w_left_valid = w_valid[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_right_valid = 1'b0;
                assign w_right_data  = '0;
            end else begin : g_inner_r
                assign w_right_valid = w_valid[g+1];
                assign w_right_data  = w_data[g+1];
            end

            rpat_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_key         (r_key),
                .i_left_valid  (w_left_valid),
                .i_right_valid (w_right_valid),
                .i_right_data  (w_right_data),
                .i_shift       (w_shift[g]),
                .o_shift       (w_shift[g+1]),
                .o_valid       (w_valid[g]),
                .o_data        (w_data[g]),
                .o_match       (w_match),
                .o_last_match  (w_last_vec[g])
            );

            assign w_valid_vec[g] = w_valid[g];
            assign w_match_vec[g] = w_match;
        end
    endgenerate

    // count and result fields
    always_comb begin
        n_count = r_count;
        if (r_action == rpat_pkg::ACT_CLEAR) begin
            n_count = '0;
        end else if (w_learn_en & ~w_hit & ~w_full) begin
            n_count = r_count + CW'(1);
        end
    end

    assign w_matched   = (r_action == rpat_pkg::ACT_LOOKUP) & r_enable & w_hit;
    assign w_changed   = (r_action == rpat_pkg::ACT_CLEAR)
                       | (w_learn_en & ~(w_hit & w_last_hit));
    assign w_count_ext = (CW + rpat_pkg::COUNT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_upd) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_upd) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_m_data <= {1'b0, w_count_ext[rpat_pkg::COUNT_W-1:0], w_changed, w_matched};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef SYNTHESIS
    // count never exceeds the number of slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // the number of used slots agrees with the count
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("valid slots disagree with entry count");

    // an address is held at most once
    a_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("address matched in more than one slot");

    // an accepted word is always followed by its compare cycle
    a_cmp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> r_state == rpat_pkg::ST_CMP)
        else $error("compare cycle missing after accept");
`endif

endmodule

// ===== verif/recent_peer_address_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// recent_peer_address_table_core_tb
// Self-checking bench for the recent peer address table. A scoreboard keeps
// its own copy of the packed oldest-first list and the enable bit, works out
// matched, changed and entry_count for every accepted input word, and checks
// each result word in order. A directed pass covers key extremes, type and
// address near misses, refresh of the newest and of an older entry, the
// ignored action, clears and the disabled mode. Random phases then use a key
// pool larger than the table so that it fills and evicts, with random gaps
// on both streams and the enable bit switched between phases.
// ----------------------------------------------------------------------------
module recent_peer_address_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH         = rpat_pkg::TABLE_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned POOL_SIZE     = 24;
    localparam int unsigned MAX_REPORTS   = 10;
    // the one action code the package leaves unnamed; the block ignores it
    localparam logic [rpat_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

    // result word layout, lowest bit last in the declaration
    typedef struct packed {
        logic [rpat_pkg::COUNT_W-1:0] entry_count;
        logic                         changed;
        logic                         matched;
    } t_result;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the table and checks result words in order
    // ------------------------------------------------------------------------
    class peer_table_scoreboard;
        rpat_pkg::t_entry slots [DEPTH];
        int unsigned      used;
        bit               enable;
        t_result          awaited [$];
        int unsigned      mismatches, words_in, words_out;
        int unsigned      hits, appends, evictions, moves, stays, clears;

        function new();
            foreach (slots[i]) slots[i] = '0;
            used = 0;
            enable = 1'b1;
            mismatches = 0;
            words_in = 0;
            words_out = 0;
            hits = 0;
            appends = 0;
            evictions = 0;
            moves = 0;
            stays = 0;
            clears = 0;
        endfunction

        function void set_enable(bit value);
            enable = value;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function int find_slot(rpat_pkg::t_entry key);
            for (int i = 0; i < int'(used); i++) begin
                if (slots[i] == key) return i;
            end
            return -1;
        endfunction

        // close the gap at pos, everything newer moves one slot down
        function void drop_slot(int unsigned pos);
            for (int unsigned i = pos; i + 1 < DEPTH; i++) slots[i] = slots[i + 1];
            slots[DEPTH - 1] = '0;
        endfunction

        function void note_word(logic [rpat_pkg::ACTION_W-1:0] action,
                                rpat_pkg::t_entry key);
            t_result res;
            int      pos;
            res = '0;
            words_in++;
            case (action)
                rpat_pkg::ACT_LOOKUP: begin
                    if (enable && find_slot(key) >= 0) begin
                        res.matched = 1'b1;
                        hits++;
                    end
                end
                rpat_pkg::ACT_LEARN: begin
                    if (enable) begin
                        pos = find_slot(key);
                        if (pos >= 0) begin
                            // refresh: already newest means no change
                            if (pos + 1 != int'(used)) begin
                                drop_slot(pos);
                                slots[used - 1] = key;
                                res.changed = 1'b1;
                                moves++;
                            end else begin
                                stays++;
                            end
                        end else begin
                            if (used >= DEPTH) begin
                                drop_slot(0);
                                used = DEPTH - 1;
                                evictions++;
                            end
                            slots[used] = key;
                            used++;
                            res.changed = 1'b1;
                            appends++;
                        end
                    end
                end
                rpat_pkg::ACT_CLEAR: begin
                    // clear ignores enable and always reports a change
                    foreach (slots[i]) slots[i] = '0;
                    used = 0;
                    res.changed = 1'b1;
                    clears++;
                end
                default: ;
            endcase
            res.entry_count = (rpat_pkg::COUNT_W)'(used);
            awaited.push_back(res);
        endfunction

        function void check_word(logic [7:0] data);
            t_result got, want;
            got = data[6:0];
            words_out++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word %h, nothing awaited", $realtime, data);
                return;
            end
            want = awaited.pop_front();
            if (got.matched !== want.matched || got.changed !== want.changed ||
                got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result %0d: matched %b/%b changed %b/%b",
                              " count %0d/%0d (exp/got)"},
                             $realtime, words_out, want.matched, got.matched, want.changed,
                             got.changed, want.entry_count, got.entry_count);
            end
        endfunction

        function void finish_check();
            if (awaited.size() != 0) begin
                mismatches += awaited.size();
                $display("%0d result words never arrived", awaited.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [55:0]                   i_s_tdata;
    logic [rpat_pkg::ACTION_W-1:0] i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [7:0]                    o_m_tdata;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_data;

    peer_table_scoreboard sb;
    rpat_pkg::t_entry     pool [POOL_SIZE];
    rpat_pkg::t_entry     last_learned;
    bit                   no_gaps;
    int unsigned          cycle_count = 0;

    recent_peer_address_table_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, none during the steady stretch
    always @(negedge i_clk) begin
        i_m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // result word check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_word(o_m_tdata);
    end

    // ------------------------------------------------------------------------
    // Drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < 23);
    endfunction

    function automatic rpat_pkg::t_entry fresh_key();
        rpat_pkg::t_entry key;
        key.dev_type = 8'($urandom);
        key.address  = {16'($urandom), 32'($urandom)};
        return key;
    endfunction

    function automatic rpat_pkg::t_entry mk(logic [rpat_pkg::TYPE_W-1:0] kind,
                                            logic [rpat_pkg::ADDR_W-1:0] addr);
        rpat_pkg::t_entry key;
        key.dev_type = kind;
        key.address  = addr;
        return key;
    endfunction

    task automatic send_word(logic [rpat_pkg::ACTION_W-1:0] action, rpat_pkg::t_entry key);
        while (take_gap()) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= {key.address, key.dev_type};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(action, key);
        if (action == rpat_pkg::ACT_LEARN) last_learned = key;
        @(negedge i_clk);
    endtask

    // hold the input back until every result word is in, then let it settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_enable(bit value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_enable(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly learns and lookups on a pool bigger than the table
    task automatic random_word();
        int unsigned      roll;
        rpat_pkg::t_entry key;
        logic [55:0]      flat;
        roll = $urandom_range(99);
        key  = pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < 2) begin
            send_word(rpat_pkg::ACT_CLEAR, fresh_key());
        end else if (roll < 6) begin
            send_word(ACT_NONE, fresh_key());
        end else if (roll < 10) begin
            send_word(rpat_pkg::ACT_LEARN, last_learned);
        end else if (roll < 52) begin
            if ($urandom_range(99) < 15) key = fresh_key();
            send_word(rpat_pkg::ACT_LEARN, key);
        end else begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                // one bit away from a known key
                flat = key;
                flat[$urandom_range(55)] ^= 1'b1;
                key = flat;
            end else if (roll < 25) begin
                key = fresh_key();
            end
            send_word(rpat_pkg::ACT_LOOKUP, key);
        end
    endtask

    task automatic random_run(int unsigned count, int unsigned calm_from, int unsigned calm_to);
        for (int unsigned i = 0; i < count; i++) begin
            no_gaps = (i >= calm_from) && (i < calm_to);
            random_word();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rpat_pkg::t_entry zero_key, ones_key, key_a, key_b;
        sb          = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = rpat_pkg::ACT_LOOKUP;
        i_m_tready  = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b1;
        no_gaps     = 1'b0;
        zero_key    = '0;
        ones_key    = '1;
        key_a       = mk(8'hA5, 48'hAAAA_5555_AAAA);
        key_b       = mk(8'h5A, 48'h5555_AAAA_5555);
        last_learned = zero_key;

        pool[0] = zero_key;
        pool[1] = ones_key;
        pool[2] = mk(8'h00, 48'hFFFF_FFFF_FFFF);
        pool[3] = mk(8'hFF, 48'h0);
        for (int i = 4; i < POOL_SIZE; i++) pool[i] = fresh_key();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_enable(1'b1);

        // directed: extremes, near misses, refreshes, ignored action, clears
        send_word(rpat_pkg::ACT_LOOKUP, zero_key);
        send_word(rpat_pkg::ACT_LEARN,  zero_key);
        send_word(rpat_pkg::ACT_LEARN,  ones_key);
        send_word(rpat_pkg::ACT_LOOKUP, zero_key);
        send_word(rpat_pkg::ACT_LOOKUP, ones_key);
        send_word(rpat_pkg::ACT_LOOKUP, mk(8'h01, 48'h0));
        send_word(rpat_pkg::ACT_LOOKUP, mk(8'h00, 48'h1));
        send_word(rpat_pkg::ACT_LOOKUP,
                  mk(8'hFF, 48'hFFFF_FFFF_FFFF) ^ 56'h80_0000_0000_0000);
        send_word(rpat_pkg::ACT_LEARN,  ones_key);
        send_word(rpat_pkg::ACT_LEARN,  zero_key);
        send_word(ACT_NONE,             ones_key);
        send_word(rpat_pkg::ACT_CLEAR,  key_a);
        send_word(rpat_pkg::ACT_CLEAR,  key_b);
        send_word(rpat_pkg::ACT_LEARN,  key_a);
        send_word(rpat_pkg::ACT_LEARN,  key_b);
        send_word(rpat_pkg::ACT_LOOKUP, key_a);
        drain();

        // directed: disabled mode, clear still works
        write_enable(1'b0);
        send_word(rpat_pkg::ACT_LOOKUP, key_a);
        send_word(rpat_pkg::ACT_LEARN,  zero_key);
        send_word(rpat_pkg::ACT_LEARN,  key_a);
        send_word(ACT_NONE,             key_b);
        send_word(rpat_pkg::ACT_CLEAR,  zero_key);
        send_word(rpat_pkg::ACT_LOOKUP, key_b);
        drain();
        write_enable(1'b1);

        // random phases with the enable bit switched in between
        random_run(220, 70, 130);
        drain();
        write_enable(1'b0);
        random_run(40, 0, 0);
        drain();
        write_enable(1'b1);
        random_run(140, 0, 0);
        drain();

        sb.finish_check();
        $display("Covered %0d input words, %0d results: %0d lookup hits, %0d appends, %0d evictions",
                 sb.words_in, sb.words_out, sb.hits, sb.appends, sb.evictions);
        $display("%0d refreshes moved to newest, %0d refreshes of newest, %0d clears, %0d mismatches",
                 sb.moves, sb.stays, sb.clears, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
